// ===== rtl/gnd_pkg.sv =====
package gnd_pkg;

	localparam int ALL_KINDS         = 7;
	localparam int KIND_W            = 3;
	localparam int DENOM_W           = 8;
	localparam int CFG_INDEX_W       = 3;
	localparam int MODE_W            = 2;
	localparam int OUTCOME_W         = 2;
	localparam int DIV_STEP          = 4;

	localparam int NOTE_KINDS_DEF    = 7;
	localparam int COUNT_WIDTH_DEF   = 16;
	localparam int AMOUNT_WIDTH_DEF  = 24;

	localparam logic [MODE_W-1:0] MODE_LOAD     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_WITHDRAW = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REPORT   = 2'd2;

	localparam logic [OUTCOME_W-1:0] OUTCOME_APPROVED = 2'd0;
	localparam logic [OUTCOME_W-1:0] OUTCOME_UNAVAIL  = 2'd1;
	localparam logic [OUTCOME_W-1:0] OUTCOME_REPORT   = 2'd2;
	localparam logic [OUTCOME_W-1:0] OUTCOME_LOADED   = 2'd3;

	localparam logic [DENOM_W-1:0] DENOMS [ALL_KINDS] = '{
		8'd200, 8'd100, 8'd50, 8'd20, 8'd10, 8'd5, 8'd2
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_SUB,
		ST_DONE
	} gnd_state_t;

	typedef struct packed {
		logic              accept;
		logic              div_step;
		logic              mul;
		logic              sub;
		logic              finish;
		logic [KIND_W-1:0] kind;
	} gnd_cmd_t;

	typedef struct packed {
		logic rest_zero;
	} gnd_status_t;

endpackage

// ===== rtl/gnd_ctrl.sv =====
module gnd_ctrl
	import gnd_pkg::*;
#(
	parameter int NOTE_KINDS   = NOTE_KINDS_DEF,
	parameter int AMOUNT_WIDTH = AMOUNT_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [MODE_W-1:0] mode,
	output logic              out_valid,
	input  logic              out_stall,
	input  gnd_status_t       status,
	output gnd_cmd_t          cmd
);

	localparam int DIV_CYCLES = (AMOUNT_WIDTH + DIV_STEP - 1) / DIV_STEP;
	localparam int DCNT_W     = $clog2(DIV_CYCLES);

	gnd_state_t        state_q, state_d;
	logic [KIND_W-1:0] kind_q, kind_d;
	logic [DCNT_W-1:0] dcnt_q, dcnt_d;
	logic              out_valid_q;
	logic              slot_free;

	assign slot_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign in_stall  = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= '0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			dcnt_q  <= dcnt_d;
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d      = state_q;
		kind_d       = kind_q;
		dcnt_d       = dcnt_q;
		cmd          = '0;
		cmd.kind     = kind_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					kind_d     = '0;
					dcnt_d     = '0;
					if (mode == MODE_WITHDRAW)
						state_d = ST_DIV;
					else if (mode == MODE_LOAD || mode == MODE_REPORT)
						state_d = ST_DONE;
				end
			end
			ST_DIV: begin
				if (dcnt_q == '0 && status.rest_zero) begin
					state_d = ST_DONE;
				end else begin
					cmd.div_step = 1'b1;
					if (dcnt_q == DCNT_W'(DIV_CYCLES - 1)) begin
						dcnt_d  = '0;
						state_d = ST_MUL;
					end else begin
						dcnt_d = dcnt_q + 1'b1;
					end
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_SUB;
			end
			ST_SUB: begin
				cmd.sub = 1'b1;
				if (kind_q == KIND_W'(NOTE_KINDS - 1)) begin
					state_d = ST_DONE;
				end else begin
					kind_d  = kind_q + 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== rtl/gnd_datapath.sv =====
module gnd_datapath
	import gnd_pkg::*;
#(
	parameter int NOTE_KINDS   = NOTE_KINDS_DEF,
	parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF,
	parameter int AMOUNT_WIDTH = AMOUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  gnd_cmd_t               cmd,
	output gnd_status_t            status,
	input  logic [MODE_W-1:0]      mode,
	input  logic [AMOUNT_WIDTH-1:0] amount,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [COUNT_WIDTH-1:0] cfg_data,
	output logic [OUTCOME_W-1:0]   outcome,
	output logic [COUNT_WIDTH-1:0] notes [ALL_KINDS]
);

	localparam int DIV_CYCLES = (AMOUNT_WIDTH + DIV_STEP - 1) / DIV_STEP;
	localparam int PW         = DIV_CYCLES * DIV_STEP;
	localparam int QX_W       = (PW > COUNT_WIDTH) ? PW : COUNT_WIDTH;
	localparam int PROD_W     = COUNT_WIDTH + DENOM_W;
	localparam int SX_W       = (PROD_W > AMOUNT_WIDTH) ? PROD_W : AMOUNT_WIDTH;

	logic [COUNT_WIDTH-1:0]  start_q [ALL_KINDS];
	logic [COUNT_WIDTH-1:0]  inv_q   [ALL_KINDS];
	logic [COUNT_WIDTH-1:0]  take_q  [ALL_KINDS];
	logic [COUNT_WIDTH-1:0]  res_q   [ALL_KINDS];
	logic [OUTCOME_W-1:0]    outcome_q;
	logic [MODE_W-1:0]       mode_q;
	logic [AMOUNT_WIDTH-1:0] rest_q;
	logic [PW-1:0]           dvd_q;
	logic [PW-1:0]           quo_q;
	logic [DENOM_W-1:0]      rem_q;
	logic [PROD_W-1:0]       prod_q;

	logic [DENOM_W-1:0]      den;
	logic [DENOM_W:0]        part;
	logic [DIV_STEP-1:0]     qbits;
	logic [DENOM_W-1:0]      rem_d;
	logic [COUNT_WIDTH-1:0]  inv_k;
	logic [COUNT_WIDTH-1:0]  n_take;
	logic [AMOUNT_WIDTH-1:0] rest_d;

	assign den              = DENOMS[cmd.kind];
	assign inv_k            = inv_q[cmd.kind];
	assign status.rest_zero = (rest_q == '0);
	assign outcome          = outcome_q;

	always_comb begin
		part  = '0;
		qbits = '0;
		rem_d = rem_q;
		for (int j = 0; j < DIV_STEP; j++) begin
			part = {rem_d, dvd_q[PW-1-j]};
			if (part >= {1'b0, den}) begin
				part              = part - {1'b0, den};
				qbits[DIV_STEP-1-j] = 1'b1;
			end
			rem_d = part[DENOM_W-1:0];
		end
	end

	always_comb begin
		if (QX_W'(quo_q) > QX_W'(inv_k))
			n_take = inv_k;
		else
			n_take = COUNT_WIDTH'(quo_q);
		rest_d = AMOUNT_WIDTH'(SX_W'(rest_q) - SX_W'(prod_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ALL_KINDS; k++) begin
				start_q[k] <= '0;
				inv_q[k]   <= '0;
			end
		end else begin
			if (cfg_we && cfg_index < CFG_INDEX_W'(ALL_KINDS))
				start_q[cfg_index] <= cfg_data;
			if (cmd.finish) begin
				for (int k = 0; k < ALL_KINDS; k++) begin
					if (k < NOTE_KINDS) begin
						if (mode_q == MODE_LOAD)
							inv_q[k] <= start_q[k];
						else if (mode_q == MODE_WITHDRAW && status.rest_zero)
							inv_q[k] <= inv_q[k] - take_q[k];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q <= mode;
			rest_q <= amount;
			dvd_q  <= PW'(amount);
			rem_q  <= '0;
			for (int k = 0; k < ALL_KINDS; k++)
				take_q[k] <= '0;
		end
		if (cmd.div_step) begin
			dvd_q <= dvd_q << DIV_STEP;
			quo_q <= {quo_q[PW-DIV_STEP-1:0], qbits};
			rem_q <= rem_d;
		end
		if (cmd.mul) begin
			take_q[cmd.kind] <= n_take;
			prod_q           <= n_take * den;
		end
		if (cmd.sub) begin
			rest_q <= rest_d;
			dvd_q  <= PW'(rest_d);
			rem_q  <= '0;
		end
		if (cmd.finish) begin
			case (mode_q)
				MODE_LOAD:     outcome_q <= OUTCOME_LOADED;
				MODE_REPORT:   outcome_q <= OUTCOME_REPORT;
				default:       outcome_q <= status.rest_zero ? OUTCOME_APPROVED
				                                            : OUTCOME_UNAVAIL;
			endcase
			for (int k = 0; k < ALL_KINDS; k++) begin
				if (k >= NOTE_KINDS)
					res_q[k] <= '0;
				else if (mode_q == MODE_LOAD)
					res_q[k] <= start_q[k];
				else if (mode_q == MODE_REPORT)
					res_q[k] <= inv_q[k];
				else if (status.rest_zero)
					res_q[k] <= take_q[k];
				else
					res_q[k] <= '0;
			end
		end
	end

	always_comb begin
		for (int k = 0; k < ALL_KINDS; k++)
			notes[k] = res_q[k];
	end

endmodule

// ===== rtl/greedy_note_dispenser_core.sv =====
// Channel  Direction  Handshake               Payload
// in       sink       in_valid / in_stall     mode, amount
// out      source     out_valid / out_stall   outcome, notes_200 .. notes_2
// cfg      sink       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Load, report: accept leads to ST_DONE, and the result register is written once the output slot is free.
// Withdraw: runs ST_DIV, ST_MUL and ST_SUB for each note kind in turn,
// using one shared radix-16 constant divider plus a multiply and a subtract per note;
// it ends early once the remainder reaches zero.
// Reset clears inventory, starting counts and all control state.
// A finished result sits in the output register while the next request is accepted.
module greedy_note_dispenser_core
	import gnd_pkg::*;
#(
	parameter int NOTE_KINDS   = NOTE_KINDS_DEF,
	parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF,
	parameter int AMOUNT_WIDTH = AMOUNT_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [MODE_W-1:0]       mode,
	input  logic [AMOUNT_WIDTH-1:0] amount,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [OUTCOME_W-1:0]    outcome,
	output logic [COUNT_WIDTH-1:0]  notes_200,
	output logic [COUNT_WIDTH-1:0]  notes_100,
	output logic [COUNT_WIDTH-1:0]  notes_50,
	output logic [COUNT_WIDTH-1:0]  notes_20,
	output logic [COUNT_WIDTH-1:0]  notes_10,
	output logic [COUNT_WIDTH-1:0]  notes_5,
	output logic [COUNT_WIDTH-1:0]  notes_2,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_INDEX_W-1:0]  cfg_index,
	input  logic [COUNT_WIDTH-1:0]  cfg_data
);

	gnd_cmd_t               cmd;
	gnd_status_t            status;
	logic [COUNT_WIDTH-1:0] notes [ALL_KINDS];

	assign cfg_ready = 1'b1;

	gnd_ctrl #(
		.NOTE_KINDS   (NOTE_KINDS),
		.AMOUNT_WIDTH (AMOUNT_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	gnd_datapath #(
		.NOTE_KINDS   (NOTE_KINDS),
		.COUNT_WIDTH  (COUNT_WIDTH),
		.AMOUNT_WIDTH (AMOUNT_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.mode      (mode),
		.amount    (amount),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.outcome   (outcome),
		.notes     (notes)
	);

	assign notes_200 = notes[0];
	assign notes_100 = notes[1];
	assign notes_50  = notes[2];
	assign notes_20  = notes[3];
	assign notes_10  = notes[4];
	assign notes_5   = notes[5];
	assign notes_2   = notes[6];

	a_withdraw_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && mode == MODE_WITHDRAW |=> in_stall)
		else $error("withdraw request did not occupy the block");

	a_short_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (mode == MODE_LOAD || mode == MODE_REPORT) |=> in_stall)
		else $error("load or report request did not occupy the block");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a request in flight");

endmodule
